// ===== src/dfr_pkg.sv =====
// Shared types, constants and helpers for the delimited frame receiver.
package dfr_pkg;

  localparam int BUF_DEPTH = 32;
  localparam int ADDR_W    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

  localparam int BYTE_W = 8;
  localparam int IDX_W  = 5;
  localparam int LEN_W  = 6;
  localparam int REQ_W  = 2;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [REQ_W-1:0] {
    REQ_BYTE = 2'd0,
    REQ_POLL = 2'd1,
    REQ_READ = 2'd2
  } req_t;

  typedef enum logic {
    REG_START_DELIM = 1'b0,
    REG_END_DELIM   = 1'b1
  } reg_idx_t;

  // Input request, lowest field in the lowest bits.
  typedef struct packed {
    logic [IDX_W-1:0]  read_index;
    logic [BYTE_W-1:0] rx_byte;
  } in_item_t;

  // Result, lowest field in the lowest bits.
  typedef struct packed {
    logic              overflow;
    logic [BYTE_W-1:0] read_byte;
    logic [LEN_W-1:0]  frame_length;
    logic              frame_ready;
    logic [BYTE_W-1:0] echo_byte;
    logic              echo_valid;
  } out_item_t;

  localparam int IN_ITEM_W  = $bits(in_item_t);
  localparam int OUT_ITEM_W = $bits(out_item_t);

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } buf_wr_t;

  function automatic logic [ADDR_W-1:0] idx_to_addr(input logic [IDX_W-1:0] idx);
    logic [IDX_W+ADDR_W-1:0] ext;
    ext = (IDX_W + ADDR_W)'(idx);
    return ext[ADDR_W-1:0];
  endfunction

  function automatic logic idx_in_range(input logic [IDX_W-1:0] idx);
    logic [IDX_W+ADDR_W-1:0] ext;
    ext = (IDX_W + ADDR_W)'(idx);
    return ext < (IDX_W + ADDR_W)'(BUF_DEPTH);
  endfunction

endpackage

// ===== src/dfr_buffer.sv =====
// Frame buffer memory: one write port, one registered read port with write bypass.
module dfr_buffer (
  input  logic                                clk,
  input  dfr_pkg::buf_wr_t                    wr,
  input  logic                                rd_en,
  input  logic [dfr_pkg::ADDR_W-1:0]          rd_addr,
  output logic [dfr_pkg::BYTE_W-1:0]          rd_data
);

  logic [dfr_pkg::BYTE_W-1:0] mem [dfr_pkg::BUF_DEPTH];
  logic [dfr_pkg::BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Forward a write landing in the same cycle as the read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr.en && (wr.addr == rd_addr)) begin
        rd_data_r <= wr.data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/dfr_core.sv =====
// Frame capture state and per-request result logic.
module dfr_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  dfr_pkg::req_t                req,
  input  dfr_pkg::in_item_t            item,
  input  logic [dfr_pkg::BYTE_W-1:0]   start_delim,
  input  logic [dfr_pkg::BYTE_W-1:0]   end_delim,
  input  logic [dfr_pkg::BYTE_W-1:0]   rd_data,
  output dfr_pkg::out_item_t           result,
  output dfr_pkg::buf_wr_t             wr
);

  logic                        capture_open_r, capture_open_nxt;
  logic [dfr_pkg::CNT_W-1:0]   write_count_r, write_count_nxt;
  logic                        frame_pending_r, frame_pending_nxt;
  logic [dfr_pkg::CNT_W-1:0]   latched_length_r, latched_length_nxt;

  logic                        open_now;
  logic                        has_room;
  logic [dfr_pkg::CNT_W-1:0]   count_after;

  always_comb begin
    capture_open_nxt   = capture_open_r;
    write_count_nxt    = write_count_r;
    frame_pending_nxt  = frame_pending_r;
    latched_length_nxt = latched_length_r;
    result             = '0;
    wr                 = '0;
    open_now           = capture_open_r || (item.rx_byte == start_delim);
    has_room           = write_count_r < dfr_pkg::CNT_W'(dfr_pkg::BUF_DEPTH);
    count_after        = write_count_r;

    unique case (req)
      dfr_pkg::REQ_BYTE: begin
        if (open_now) begin
          result.echo_valid = 1'b1;
          result.echo_byte  = item.rx_byte;
          if (has_room) begin
            wr.en       = 1'b1;
            wr.addr     = write_count_r[dfr_pkg::ADDR_W-1:0];
            wr.data     = item.rx_byte;
            count_after = write_count_r + dfr_pkg::CNT_W'(1);
          end else begin
            result.overflow = 1'b1;
          end
        end
        if (item.rx_byte == end_delim) begin
          frame_pending_nxt  = 1'b1;
          latched_length_nxt = count_after;
          write_count_nxt    = '0;
          capture_open_nxt   = 1'b0;
        end else begin
          write_count_nxt  = count_after;
          capture_open_nxt = open_now;
        end
      end
      dfr_pkg::REQ_POLL: begin
        if (frame_pending_r) begin
          result.frame_ready  = 1'b1;
          result.frame_length = dfr_pkg::LEN_W'(latched_length_r);
          frame_pending_nxt   = 1'b0;
          latched_length_nxt  = '0;
        end
      end
      dfr_pkg::REQ_READ: begin
        if (dfr_pkg::idx_in_range(item.read_index)) begin
          result.read_byte = rd_data;
        end
      end
      default: begin
        // unknown request: no change, all-zero result
      end
    endcase

    if (!adv) begin
      wr.en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capture_open_r   <= 1'b0;
      write_count_r    <= '0;
      frame_pending_r  <= 1'b0;
      latched_length_r <= '0;
    end else if (adv) begin
      capture_open_r   <= capture_open_nxt;
      write_count_r    <= write_count_nxt;
      frame_pending_r  <= frame_pending_nxt;
      latched_length_r <= latched_length_nxt;
    end
  end

endmodule

// ===== src/delimited_frame_receiver.sv =====
// Delimited frame receiver: one request per cycle, passing from input to result through
// the input register, then the result register, with the frame buffer written once and
// read once per cycle through its single write port and registered read port; both
// stages hold under output backpressure and a new request enters whenever the input
// register moves on. Requests are received bytes, status polls and buffer reads;
// delimiters are set through the register port and reset to 0x02 (start) and 0x03 (end).
module delimited_frame_receiver (
  input  logic                               clk,
  input  logic                               rst_n,
  // Request channel
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [dfr_pkg::IN_DATA_W-1:0]      in_tdata,  // rx_byte[7:0], read_index[12:8], 0
  input  logic [dfr_pkg::REQ_W-1:0]          in_tuser,  // req_type[1:0]
  // Result channel
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // echo_valid[0], echo_byte[8:1], frame_ready[9], frame_length[15:10],
  // read_byte[23:16], overflow[24], 0
  output logic [dfr_pkg::OUT_DATA_W-1:0]     out_tdata,
  // Register port
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [dfr_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [dfr_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [dfr_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                               cfg_pready
);

  logic [dfr_pkg::BYTE_W-1:0] start_delim_r;
  logic [dfr_pkg::BYTE_W-1:0] end_delim_r;
  logic                       cfg_wr;
  dfr_pkg::reg_idx_t          cfg_reg;

  logic                       s1_valid_r;
  dfr_pkg::req_t              s1_req_r;
  dfr_pkg::in_item_t          s1_item_r;
  logic                       s1_adv;
  logic                       in_accept;
  dfr_pkg::in_item_t          in_item;

  logic                       out_valid_r;
  dfr_pkg::out_item_t         out_item_r;
  dfr_pkg::out_item_t         result;

  dfr_pkg::buf_wr_t           buf_wr;
  logic [dfr_pkg::BYTE_W-1:0] buf_rd_data;

  // Register port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_reg    = dfr_pkg::reg_idx_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_delim_r <= 8'd2;
      end_delim_r   <= 8'd3;
    end else if (cfg_wr) begin
      unique case (cfg_reg)
        dfr_pkg::REG_START_DELIM: start_delim_r <= cfg_pwdata[dfr_pkg::BYTE_W-1:0];
        dfr_pkg::REG_END_DELIM:   end_delim_r   <= cfg_pwdata[dfr_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg)
      dfr_pkg::REG_START_DELIM: cfg_prdata = dfr_pkg::CFG_DATA_W'(start_delim_r);
      dfr_pkg::REG_END_DELIM:   cfg_prdata = dfr_pkg::CFG_DATA_W'(end_delim_r);
      default:                  cfg_prdata = '0;
    endcase
  end

  // Input register
  assign in_item   = dfr_pkg::in_item_t'(in_tdata[dfr_pkg::IN_ITEM_W-1:0]);
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_req_r  <= dfr_pkg::req_t'(in_tuser);
      s1_item_r <= in_item;
    end
  end

  dfr_buffer u_buffer (
    .clk     (clk),
    .wr      (buf_wr),
    .rd_en   (in_accept),
    .rd_addr (dfr_pkg::idx_to_addr(in_item.read_index)),
    .rd_data (buf_rd_data)
  );

  dfr_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (s1_adv),
    .req         (s1_req_r),
    .item        (s1_item_r),
    .start_delim (start_delim_r),
    .end_delim   (end_delim_r),
    .rd_data     (buf_rd_data),
    .result      (result),
    .wr          (buf_wr)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_item_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = dfr_pkg::OUT_DATA_W'(out_item_r);

endmodule

// ===== src/dfr_checker.sv =====
// Port-level checks for the delimited frame receiver, bound to the top level.
module dfr_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [dfr_pkg::OUT_DATA_W-1:0]  out_tdata
);

  dfr_pkg::out_item_t res;

  assign res = dfr_pkg::out_item_t'(out_tdata[dfr_pkg::OUT_ITEM_W-1:0]);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // An echo result never carries poll or read data.
  a_kind_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.echo_valid |-> !res.frame_ready && (res.read_byte == '0))
    else $error("echo result carries poll or read data");

  // Drop only an echoed byte.
  a_ovf_echo: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.overflow |-> res.echo_valid)
    else $error("overflow without echo");

  // Report a length only with a ready frame, never past buffer depth.
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (res.frame_ready || (res.frame_length == '0)) &&
                   (32'(res.frame_length) <= 32'(dfr_pkg::BUF_DEPTH)))
    else $error("bad frame length");

endmodule

bind delimited_frame_receiver dfr_checker u_dfr_checker (.*);

// ===== sim/tb_top.sv =====
// Testbench for the delimited frame receiver: directed table, random frames, scoreboard.
`timescale 1ns / 100ps

module tb_top;
  import dfr_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DIR_ROWS = 26;

  // One directed request, repeated reps times; res is checked only when typed is set.
  typedef struct packed {
    logic [REQ_W-1:0]  kind;
    logic [BYTE_W-1:0] rx_val;
    logic [IDX_W-1:0]  idx;
    logic [5:0]        reps;
    logic              typed;
    out_item_t         res;
  } stim_row_t;

  // res fields from the top: overflow, read_byte, frame_length, frame_ready, echo_byte, echo_valid
  localparam stim_row_t DIR_TAB [DIR_ROWS] = '{
    '{REQ_POLL,    8'h00, 5'd0,  6'd1,  1'b1, '{1'b0, 8'h00, 6'd0,  1'b0, 8'h00, 1'b0}},
    '{REQ_UNKNOWN, 8'hff, 5'd31, 6'd1,  1'b1, '{1'b0, 8'h00, 6'd0,  1'b0, 8'h00, 1'b0}},
    '{REQ_BYTE,    8'h00, 5'd0,  6'd1,  1'b1, '{1'b0, 8'h00, 6'd0,  1'b0, 8'h00, 1'b0}},
    '{REQ_BYTE,    8'h03, 5'd0,  6'd1,  1'b1, '{1'b0, 8'h00, 6'd0,  1'b0, 8'h00, 1'b0}},
    '{REQ_POLL,    8'h00, 5'd0,  6'd1,  1'b1, '{1'b0, 8'h00, 6'd0,  1'b1, 8'h00, 1'b0}},
    '{REQ_POLL,    8'h00, 5'd0,  6'd1,  1'b1, '{1'b0, 8'h00, 6'd0,  1'b0, 8'h00, 1'b0}},
    '{REQ_BYTE,    8'h02, 5'd0,  6'd1,  1'b1, '{1'b0, 8'h00, 6'd0,  1'b0, 8'h02, 1'b1}},
    '{REQ_BYTE,    8'hff, 5'd0,  6'd1,  1'b1, '{1'b0, 8'h00, 6'd0,  1'b0, 8'hff, 1'b1}},
    '{REQ_BYTE,    8'h02, 5'd0,  6'd1,  1'b0, '0},
    '{REQ_BYTE,    8'h55, 5'd0,  6'd29, 1'b0, '0},
    '{REQ_BYTE,    8'haa, 5'd0,  6'd1,  1'b1, '{1'b1, 8'h00, 6'd0,  1'b0, 8'haa, 1'b1}},
    '{REQ_BYTE,    8'h03, 5'd0,  6'd1,  1'b1, '{1'b1, 8'h00, 6'd0,  1'b0, 8'h03, 1'b1}},
    '{REQ_POLL,    8'h00, 5'd0,  6'd1,  1'b1, '{1'b0, 8'h00, 6'd32, 1'b1, 8'h00, 1'b0}},
    '{REQ_READ,    8'h00, 5'd0,  6'd1,  1'b1, '{1'b0, 8'h02, 6'd0,  1'b0, 8'h00, 1'b0}},
    '{REQ_READ,    8'h00, 5'd31, 6'd1,  1'b1, '{1'b0, 8'h55, 6'd0,  1'b0, 8'h00, 1'b0}},
    '{REQ_READ,    8'h00, 5'd1,  6'd1,  1'b1, '{1'b0, 8'hff, 6'd0,  1'b0, 8'h00, 1'b0}},
    '{REQ_UNKNOWN, 8'h00, 5'd0,  6'd1,  1'b1, '{1'b0, 8'h00, 6'd0,  1'b0, 8'h00, 1'b0}},
    '{REQ_BYTE,    8'h02, 5'd0,  6'd1,  1'b0, '0},
    '{REQ_BYTE,    8'h00, 5'd0,  6'd1,  1'b0, '0},
    '{REQ_BYTE,    8'h03, 5'd0,  6'd1,  1'b0, '0},
    '{REQ_BYTE,    8'h02, 5'd0,  6'd1,  1'b0, '0},
    '{REQ_BYTE,    8'h11, 5'd0,  6'd1,  1'b0, '0},
    '{REQ_UNKNOWN, 8'h02, 5'd0,  6'd1,  1'b0, '0},
    '{REQ_BYTE,    8'h03, 5'd0,  6'd1,  1'b0, '0},
    '{REQ_POLL,    8'h00, 5'd0,  6'd1,  1'b0, '0},
    '{REQ_READ,    8'h00, 5'd2,  6'd1,  1'b0, '0}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // rx_byte[7:0], read_index[12:8], 0
  logic [REQ_W-1:0]      in_tuser;   // req_type[1:0]
  logic                  out_tvalid;
  logic                  out_tready;
  // echo_valid[0], echo_byte[8:1], frame_ready[9], frame_length[15:10],
  // read_byte[23:16], overflow[24], 0
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  delimited_frame_receiver dut (.*);

  // Receiver model state
  logic [BYTE_W-1:0] start_delim = 8'h02;
  logic [BYTE_W-1:0] end_delim   = 8'h03;
  logic              cap_open    = 1'b0;
  int                wr_count    = 0;
  logic              frame_pending = 1'b0;
  logic [LEN_W-1:0]  held_len    = '0;
  logic [BYTE_W-1:0] frame_buf [BUF_DEPTH];
  bit                buf_written [BUF_DEPTH];

  out_item_t pending_responses [$];
  int        err_count   = 0;
  int        items_sent  = 0;
  int        cycle_count = 0;
  int        gap_rate    = 20;
  int        stall_left  = 0;
  out_item_t mon_want;
  out_item_t mon_seen;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic out_item_t predict_response(input logic [REQ_W-1:0] kind,
                                                 input logic [BYTE_W-1:0] b,
                                                 input logic [IDX_W-1:0] ix);
    out_item_t r;
    r = '0;
    case (kind)
      REQ_BYTE: begin
        if (b == start_delim) cap_open = 1'b1;
        if (cap_open) begin
          r.echo_valid = 1'b1;
          r.echo_byte  = b;
          if (wr_count < BUF_DEPTH) begin
            frame_buf[wr_count[ADDR_W-1:0]]   = b;
            buf_written[wr_count[ADDR_W-1:0]] = 1'b1;
            wr_count++;
          end else begin
            r.overflow = 1'b1;
          end
        end
        if (b == end_delim) begin
          frame_pending = 1'b1;
          held_len      = LEN_W'(wr_count);
          wr_count      = 0;
          cap_open      = 1'b0;
        end
      end
      REQ_POLL: begin
        if (frame_pending) begin
          r.frame_ready  = 1'b1;
          r.frame_length = held_len;
          frame_pending  = 1'b0;
          held_len       = '0;
        end
      end
      REQ_READ: begin
        if (int'(ix) < BUF_DEPTH) r.read_byte = frame_buf[ix];
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned seen);
    if (want != seen) begin
      $error("%s: expected %0h, got %0h", name, want, seen);
      err_count++;
    end
  endtask

  // Called at a falling edge; returns at a falling edge with in_tvalid still high.
  task automatic send_req(input logic [REQ_W-1:0] kind, input logic [BYTE_W-1:0] b,
                          input logic [IDX_W-1:0] ix, input logic typed,
                          input out_item_t typed_res);
    out_item_t r;
    if (gap_rate != 0 && $urandom_range(0, 99) < gap_rate) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= IN_DATA_W'({ix, b});
    do @(posedge clk); while (!in_tready);
    r = predict_response(kind, b, ix);
    pending_responses.push_back(typed ? typed_res : r);
    if (kind != REQ_UNKNOWN) items_sent++;
    @(negedge clk);
  endtask

  // Read only entries that hold data; fall back to a poll otherwise.
  task automatic send_read();
    logic [IDX_W-1:0] ix;
    ix = IDX_W'($urandom_range(0, 31));
    if (buf_written[ix]) send_req(REQ_READ, 8'($urandom), ix, 1'b0, '0);
    else send_req(REQ_POLL, 8'($urandom), ix, 1'b0, '0);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_responses.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_delim(input reg_idx_t r, input logic [BYTE_W-1:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'(4 * int'(r));
    cfg_pwdata  <= CFG_DATA_W'(v);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (r == REG_START_DELIM) start_delim = v;
    else end_delim = v;
    // read back with psel held
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    check_field(r == REG_START_DELIM ? "start_delimiter" : "end_delimiter",
                CFG_DATA_W'(v), cfg_prdata);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic run_traffic(input int quota);
    int target;
    int len;
    int n;
    logic [BYTE_W-1:0] b;
    target = items_sent + quota;
    while (items_sent < target) begin
      if ($urandom_range(0, 49) == 0) wait_idle();
      if ($urandom_range(0, 9) < 6) begin
        n = $urandom_range(0, 99);
        if (n < 85) len = $urandom_range(0, 12);
        else if (n < 95) len = $urandom_range(13, 31);
        else len = $urandom_range(32, 40);
        send_req(REQ_BYTE, start_delim, IDX_W'($urandom), 1'b0, '0);
        repeat (len) begin
          do b = 8'($urandom); while (b == end_delim);
          send_req(REQ_BYTE, b, IDX_W'($urandom), 1'b0, '0);
        end
        // drop the end delimiter now and then to leave a broken frame
        if ($urandom_range(0, 9) != 0)
          send_req(REQ_BYTE, end_delim, IDX_W'($urandom), 1'b0, '0);
        if ($urandom_range(0, 9) < 7)
          send_req(REQ_POLL, 8'($urandom), IDX_W'($urandom), 1'b0, '0);
        repeat ($urandom_range(0, 3)) send_read();
      end else begin
        n = $urandom_range(0, 9);
        if (n < 5) send_req(REQ_BYTE, 8'($urandom), IDX_W'($urandom), 1'b0, '0);
        else if (n < 7) send_req(REQ_POLL, 8'($urandom), IDX_W'($urandom), 1'b0, '0);
        else if (n < 9) send_read();
        else send_req(REQ_UNKNOWN, 8'($urandom), IDX_W'($urandom), 1'b0, '0);
      end
    end
  endtask

  // Receiver stalls in short bursts
  always @(negedge clk) begin
    if (!rst_n || gap_rate == 0) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < gap_rate) begin
      stall_left = $urandom_range(1, 6) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_responses.size() == 0) begin
        $error("unexpected response %h", out_tdata);
        err_count++;
      end else begin
        mon_want = pending_responses.pop_front();
        mon_seen = out_item_t'(out_tdata[OUT_ITEM_W-1:0]);
        check_field("echo_valid", 32'(mon_want.echo_valid), 32'(mon_seen.echo_valid));
        check_field("echo_byte", 32'(mon_want.echo_byte), 32'(mon_seen.echo_byte));
        check_field("frame_ready", 32'(mon_want.frame_ready), 32'(mon_seen.frame_ready));
        check_field("frame_length", 32'(mon_want.frame_length),
                    32'(mon_seen.frame_length));
        check_field("read_byte", 32'(mon_want.read_byte), 32'(mon_seen.read_byte));
        check_field("overflow", 32'(mon_want.overflow), 32'(mon_seen.overflow));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    logic [BYTE_W-1:0] sd;
    logic [BYTE_W-1:0] ed;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    out_tready  = 1'b1;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      repeat (DIR_TAB[i].reps)
        send_req(DIR_TAB[i].kind, DIR_TAB[i].rx_val, DIR_TAB[i].idx,
                 DIR_TAB[i].typed, DIR_TAB[i].res);
    end
    wait_idle();

    // Delimiter settings: extremes, equal, random, then back to the reset pair
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin sd = 8'h00; ed = 8'hff; gap_rate = 25; end
        1: begin sd = 8'hff; ed = 8'h00; gap_rate = 0;  end
        2: begin sd = 8'h7e; ed = 8'h7e; gap_rate = 40; end
        3: begin sd = 8'($urandom); ed = 8'($urandom); gap_rate = 15; end
        default: begin sd = 8'h02; ed = 8'h03; gap_rate = 0; end
      endcase
      write_delim(REG_START_DELIM, sd);
      write_delim(REG_END_DELIM, ed);
      run_traffic(180);
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
